@@ design/hhlp_pkg.sv @@
// ----------------------------------------------------------------------------
// hhlp_pkg
// Shared types and constants for the header line parser: phase codes,
// verdict status codes, character codes and the result record.
// ----------------------------------------------------------------------------
package hhlp_pkg;

	// parsing phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_NAME    = 2'd1,
		PH_CONTENT = 2'd2,
		PH_CR      = 2'd3
	} phase_t;

	// verdict status codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_INCOMPLETE = 2'd1,
		ST_MALFORMED  = 2'd2,
		ST_TOO_LONG   = 2'd3
	} status_t;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// one result item as produced by the step logic
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       is_content;
		logic       last;
		status_t    status;
		logic [7:0] name_length;
		logic [7:0] content_length;
	} res_t;

endpackage

@@ design/http_header_line_parser.sv @@
// ----------------------------------------------------------------------------
// http_header_line_parser
// Parses one HTTP header line a byte at a time, emitting lowercased name
// bytes, content bytes and a verdict item with status and lengths.
// Results are registered: a result appears in the cycle after the item that causes it.
// Throughput: one item per cycle; the single output register is refilled
// in the cycle it is taken, so only a stalled result holds back input.
// Reset: arst_n clears the phase to idle, both counts and the output valid.
// ----------------------------------------------------------------------------
module http_header_line_parser #(
	parameter int MAX_LINE_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       first,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       is_content,
	output logic       last,
	output logic [1:0] status,
	output logic [7:0] name_length,
	output logic [7:0] content_length
);

	logic           take;
	hhlp_pkg::res_t res;
	logic           valid_q;
	logic [7:0]     data_byte_q;
	logic           is_content_q;
	logic           last_q;
	logic [1:0]     status_q;
	logic [7:0]     name_length_q;
	logic [7:0]     content_length_q;

	// accept while the output register is empty or being drained
	assign in_ready = !valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// parser state and decision logic
	hhlp_fsm #(
		.MAX_LINE_BYTES(MAX_LINE_BYTES)
	) u_fsm (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.ch    (ch),
		.first (first),
		.res   (res)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= res.valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			data_byte_q      <= res.data_byte;
			is_content_q     <= res.is_content;
			last_q           <= res.last;
			status_q         <= res.status;
			name_length_q    <= res.name_length;
			content_length_q <= res.content_length;
		end
	end

	assign out_valid      = valid_q;
	assign data_byte      = data_byte_q;
	assign is_content     = is_content_q;
	assign last           = last_q;
	assign status         = status_q;
	assign name_length    = name_length_q;
	assign content_length = content_length_q;

endmodule

@@ design/hhlp_fsm.sv @@
// ----------------------------------------------------------------------------
// hhlp_fsm
// Phase and length state of the parser, with the per-byte decision logic
// that turns one accepted item into at most one result item.
// ----------------------------------------------------------------------------
module hhlp_fsm #(
	parameter int MAX_LINE_BYTES = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      ch,
	input  logic            first,
	output hhlp_pkg::res_t  res
);

	localparam int CNT_W  = $clog2(MAX_LINE_BYTES);
	localparam int SUM_W  = CNT_W + 1;
	localparam int WIDE_W = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [SUM_W-1:0] LIMIT = SUM_W'(MAX_LINE_BYTES);
	localparam logic [SUM_W-1:0] TWO   = SUM_W'(2);

	hhlp_pkg::phase_t phase_q, ph, ph_d;
	logic [CNT_W-1:0] name_cnt_q, content_cnt_q;
	logic [CNT_W-1:0] nc, cc, nc_d, cc_d;
	logic             verdict;
	hhlp_pkg::status_t vstat;
	logic             emit;
	logic             emit_content;
	logic [7:0]       emit_byte;
	logic             upper, lower, nonprint;
	logic [WIDE_W-1:0] nc_wide, cc_wide;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= hhlp_pkg::PH_IDLE;
			name_cnt_q    <= '0;
			content_cnt_q <= '0;
		end else if (take) begin
			phase_q       <= ph_d;
			name_cnt_q    <= nc_d;
			content_cnt_q <= cc_d;
		end
	end

	// byte classes
	assign upper    = (ch >= hhlp_pkg::CH_UPPER_A) && (ch <= hhlp_pkg::CH_UPPER_Z);
	assign lower    = (ch >= hhlp_pkg::CH_LOWER_A) && (ch <= hhlp_pkg::CH_LOWER_Z);
	assign nonprint = (ch < hhlp_pkg::CH_SPACE) || (ch >= hhlp_pkg::CH_DEL);

	// next state and result for the byte at the input
	always_comb begin
		ph   = first ? hhlp_pkg::PH_NAME : phase_q;
		nc   = first ? '0 : name_cnt_q;
		cc   = first ? '0 : content_cnt_q;
		ph_d = ph;
		nc_d = nc;
		cc_d = cc;
		verdict      = 1'b0;
		vstat        = hhlp_pkg::ST_OK;
		emit         = 1'b0;
		emit_content = 1'b0;
		emit_byte    = ch;
		unique case (ph)
			hhlp_pkg::PH_IDLE: begin
			end
			hhlp_pkg::PH_CR: begin
				verdict = 1'b1;
				vstat   = (ch == hhlp_pkg::CH_LF) ? hhlp_pkg::ST_OK
				                                  : hhlp_pkg::ST_INCOMPLETE;
			end
			hhlp_pkg::PH_NAME, hhlp_pkg::PH_CONTENT: begin
				priority if (ch == hhlp_pkg::CH_NUL) begin
					verdict = 1'b1;
					vstat   = hhlp_pkg::ST_INCOMPLETE;
				end else if (ch == hhlp_pkg::CH_CR) begin
					if (ph == hhlp_pkg::PH_NAME) begin
						verdict = 1'b1;
						vstat   = hhlp_pkg::ST_INCOMPLETE;
					end else begin
						ph_d = hhlp_pkg::PH_CR;
					end
				end else if (nonprint) begin
					verdict = 1'b1;
					vstat   = hhlp_pkg::ST_MALFORMED;
				end else if (ph == hhlp_pkg::PH_NAME) begin
					priority if (ch == hhlp_pkg::CH_COLON) begin
						ph_d = hhlp_pkg::PH_CONTENT;
					end else if (SUM_W'(nc) + TWO >= LIMIT) begin
						verdict = 1'b1;
						vstat   = hhlp_pkg::ST_TOO_LONG;
					end else if (ch != hhlp_pkg::CH_HYPHEN && !upper && !lower) begin
						verdict = 1'b1;
						vstat   = hhlp_pkg::ST_MALFORMED;
					end else begin
						emit      = 1'b1;
						emit_byte = upper ? ch + hhlp_pkg::CASE_OFFSET : ch;
						nc_d      = nc + CNT_W'(1);
					end
				end else begin
					// content: leading spaces skipped
					priority if (ch == hhlp_pkg::CH_SPACE && cc == '0) begin
					end else if (SUM_W'(nc) + SUM_W'(cc) + TWO >= LIMIT) begin
						verdict = 1'b1;
						vstat   = hhlp_pkg::ST_TOO_LONG;
					end else begin
						emit         = 1'b1;
						emit_content = 1'b1;
						cc_d         = cc + CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
		if (verdict) begin
			ph_d = hhlp_pkg::PH_IDLE;
		end
	end

	// lengths widened for saturation in the verdict
	assign nc_wide = WIDE_W'(nc);
	assign cc_wide = WIDE_W'(cc);

	// result record
	always_comb begin
		res.valid          = verdict || emit;
		res.data_byte      = emit ? emit_byte : 8'h00;
		res.is_content     = emit && emit_content;
		res.last           = verdict;
		res.status         = verdict ? vstat : hhlp_pkg::ST_OK;
		res.name_length    = 8'h00;
		res.content_length = 8'h00;
		if (verdict) begin
			res.name_length    = (nc_wide > WIDE_W'(255)) ? 8'hFF : nc_wide[7:0];
			res.content_length = (cc_wide > WIDE_W'(255)) ? 8'hFF : cc_wide[7:0];
		end
	end

	// a verdict always leaves the parser idle
	a_verdict_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.valid && res.last |=> phase_q == hhlp_pkg::PH_IDLE)
		else $error("phase not idle after verdict");

	// counts never reach the line limit
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(name_cnt_q) + SUM_W'(content_cnt_q) + TWO <= LIMIT)
		else $error("line counts beyond limit");

	// a name byte is only emitted while parsing the name
	a_name_phase: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.valid && !res.last && !res.is_content |=>
		phase_q == hhlp_pkg::PH_NAME && name_cnt_q != '0)
		else $error("name byte outside name phase");

endmodule
